// ===== hdl/isfs_pkg.sv =====
// Shared types, constants and helpers of the IMU sample frame serializer.
package isfs_pkg;

  localparam int unsigned WORD_COUNT = 6;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned DATA_W     = WORD_COUNT * WORD_W;
  localparam int unsigned WSUM_W     = 10;
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned CNT_W      = 6;

  localparam logic FMT_BIN = 1'b0;
  localparam logic FMT_HEX = 1'b1;

  localparam logic [7:0] BIN_SYNC0 = 8'hAC;
  localparam logic [7:0] BIN_SYNC1 = 8'hCA;
  localparam logic [7:0] BIN_LEN   = 8'd24;
  localparam logic [7:0] ASCII_COMMA = 8'h2C;
  localparam logic [7:0] ASCII_CR    = 8'h0D;
  localparam logic [7:0] ASCII_LF    = 8'h0A;

  // Byte positions within a frame.
  localparam logic [CNT_W-1:0] BIN_POS_SYNC1    = 6'd1;
  localparam logic [CNT_W-1:0] BIN_POS_LEN      = 6'd2;
  localparam logic [CNT_W-1:0] BIN_POS_DATA_END = 6'd26;
  localparam logic [CNT_W-1:0] BIN_POS_LAST     = 6'd27;
  localparam logic [CNT_W-1:0] HEX_POS_CSUM_HI  = 6'd54;
  localparam logic [CNT_W-1:0] HEX_POS_CSUM_LO  = 6'd55;
  localparam logic [CNT_W-1:0] HEX_POS_CR       = 6'd56;
  localparam logic [CNT_W-1:0] HEX_POS_LAST     = 6'd57;
  localparam logic [3:0]       HEX_SUB_COMMA    = 4'd8;

  typedef struct packed {
    logic              fmt;
    logic [7:0]        csum;
    logic [DATA_W-1:0] words;  // gyro_x in the top bits, accel_z in the bottom
  } isfs_frame_t;

  typedef struct packed {
    logic push;
    logic pop;
  } isfs_fifo_ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } isfs_fifo_sts_t;

  function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = 8'h30 + {4'd0, nib};
    end else begin
      r = 8'h37 + {4'd0, nib};
    end
    return r;
  endfunction

  function automatic logic [WSUM_W-1:0] word_byte_sum(input logic [WORD_W-1:0] w);
    logic [WSUM_W-1:0] s;
    s = {2'd0, w[31:24]} + {2'd0, w[23:16]} + {2'd0, w[15:8]} + {2'd0, w[7:0]};
    return s;
  endfunction

endpackage

// ===== hdl/isfs_front.sv =====
// Front end: format register, sample set capture and checksum build.
module isfs_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic                         cfg_wdata,
  input  logic                         start,
  output logic                         busy,
  input  logic [isfs_pkg::DATA_W-1:0]  in_words,
  input  isfs_pkg::isfs_fifo_sts_t     fifo_sts,
  output logic                         push,
  output isfs_pkg::isfs_frame_t        frame
);

  logic                        fmt_cfg_r;
  logic                        fe_valid_r;
  logic                        fmt_r;
  logic [isfs_pkg::DATA_W-1:0] words_r;
  logic [isfs_pkg::WSUM_W-1:0] wsum_r [isfs_pkg::WORD_COUNT];
  logic                        accept;
  logic [7:0]                  sum8;

  assign busy   = fe_valid_r && fifo_sts.full;
  assign accept = start && !busy;
  assign push   = fe_valid_r && !fifo_sts.full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_cfg_r  <= isfs_pkg::FMT_BIN;
      fe_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        fmt_cfg_r <= cfg_wdata;
      end
      if (accept) begin
        fe_valid_r <= 1'b1;
      end else if (push) begin
        fe_valid_r <= 1'b0;
      end
    end
  end

  // Per-word byte sums are taken at capture; the six partials are folded on push.
  always_ff @(posedge clk) begin
    if (accept) begin
      fmt_r   <= fmt_cfg_r;
      words_r <= in_words;
      for (int i = 0; i < isfs_pkg::WORD_COUNT; i++) begin
        wsum_r[i] <= isfs_pkg::word_byte_sum(
          in_words[isfs_pkg::DATA_W-1-i*isfs_pkg::WORD_W -: isfs_pkg::WORD_W]);
      end
    end
  end

  always_comb begin
    sum8 = 8'(wsum_r[0]) + 8'(wsum_r[1]) + 8'(wsum_r[2])
         + 8'(wsum_r[3]) + 8'(wsum_r[4]) + 8'(wsum_r[5]);
    frame.fmt   = fmt_r;
    frame.words = words_r;
    frame.csum  = (fmt_r == isfs_pkg::FMT_BIN) ? sum8 + isfs_pkg::BIN_LEN : sum8;
  end

endmodule

// ===== hdl/isfs_fifo.sv =====
// Short frame queue between the front end and the serializer.
module isfs_fifo #(
  parameter int unsigned Depth = isfs_pkg::FIFO_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  isfs_pkg::isfs_fifo_ctl_t  ctl,
  output isfs_pkg::isfs_fifo_sts_t  sts,
  input  isfs_pkg::isfs_frame_t     wr_data,
  output isfs_pkg::isfs_frame_t     rd_data
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  isfs_pkg::isfs_frame_t mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r;
  logic [PtrW-1:0] rd_ptr_r;
  logic [CntW-1:0] count_r;

  assign sts.full  = (count_r == CntW'(Depth));
  assign sts.empty = (count_r == '0);
  assign rd_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (ctl.push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (ctl.pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (ctl.push && !ctl.pop) begin
        count_r <= count_r + 1'b1;
      end else if (ctl.pop && !ctl.push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.push |-> !sts.full) else $error("frame queue overflow");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.pop |-> !sts.empty) else $error("frame queue underflow");
`endif

endmodule

// ===== hdl/isfs_back.sv =====
// Serializer: turns one queued frame into a byte stream, one beat per cycle.
module isfs_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  isfs_pkg::isfs_fifo_sts_t  fifo_sts,
  input  isfs_pkg::isfs_frame_t     frame,
  output logic                      pop,
  output logic                      out_valid,
  output logic [7:0]                out_byte,
  output logic                      out_frame_end
);

  logic                          active_r;
  logic [isfs_pkg::CNT_W-1:0]    cnt_r;
  logic [3:0]                    sub_r;
  logic                          fmt_r;
  logic [7:0]                    csum_r;
  logic [isfs_pkg::DATA_W-1:0]   data_r;
  logic                          out_valid_r;
  logic [7:0]                    out_byte_r;
  logic                          out_frame_end_r;

  logic [7:0] byte_nxt;
  logic       is_last;
  logic       shift8;
  logic       shift4;
  logic       sub_clr;

  always_comb begin
    byte_nxt = 8'd0;
    is_last  = 1'b0;
    shift8   = 1'b0;
    shift4   = 1'b0;
    sub_clr  = 1'b0;
    if (fmt_r == isfs_pkg::FMT_BIN) begin
      is_last = (cnt_r == isfs_pkg::BIN_POS_LAST);
      priority if (cnt_r == '0) begin
        byte_nxt = isfs_pkg::BIN_SYNC0;
      end else if (cnt_r == isfs_pkg::BIN_POS_SYNC1) begin
        byte_nxt = isfs_pkg::BIN_SYNC1;
      end else if (cnt_r == isfs_pkg::BIN_POS_LEN) begin
        byte_nxt = isfs_pkg::BIN_LEN;
      end else if (cnt_r <= isfs_pkg::BIN_POS_DATA_END) begin
        byte_nxt = data_r[isfs_pkg::DATA_W-1 -: 8];
        shift8   = 1'b1;
      end else begin
        byte_nxt = csum_r;
      end
    end else begin
      is_last = (cnt_r == isfs_pkg::HEX_POS_LAST);
      priority if (cnt_r < isfs_pkg::HEX_POS_CSUM_HI) begin
        if (sub_r == isfs_pkg::HEX_SUB_COMMA) begin
          byte_nxt = isfs_pkg::ASCII_COMMA;
          sub_clr  = 1'b1;
        end else begin
          byte_nxt = isfs_pkg::hex_ascii(data_r[isfs_pkg::DATA_W-1 -: 4]);
          shift4   = 1'b1;
        end
      end else if (cnt_r == isfs_pkg::HEX_POS_CSUM_HI) begin
        byte_nxt = isfs_pkg::hex_ascii(csum_r[7:4]);
      end else if (cnt_r == isfs_pkg::HEX_POS_CSUM_LO) begin
        byte_nxt = isfs_pkg::hex_ascii(csum_r[3:0]);
      end else if (cnt_r == isfs_pkg::HEX_POS_CR) begin
        byte_nxt = isfs_pkg::ASCII_CR;
      end else begin
        byte_nxt = isfs_pkg::ASCII_LF;
      end
    end
  end

  // Next frame loads on the last beat of the current one, so frames run gapless.
  assign pop = !fifo_sts.empty && (!active_r || is_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      cnt_r       <= '0;
      sub_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= active_r;
      if (pop) begin
        active_r <= 1'b1;
        cnt_r    <= '0;
        sub_r    <= '0;
      end else if (active_r && is_last) begin
        active_r <= 1'b0;
      end else if (active_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (sub_clr) begin
          sub_r <= '0;
        end else if (shift4) begin
          sub_r <= sub_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r      <= byte_nxt;
    out_frame_end_r <= active_r && is_last;
    if (pop) begin
      fmt_r  <= frame.fmt;
      csum_r <= frame.csum;
      data_r <= frame.words;
    end else if (shift8) begin
      data_r <= {data_r[isfs_pkg::DATA_W-9:0], 8'd0};
    end else if (shift4) begin
      data_r <= {data_r[isfs_pkg::DATA_W-5:0], 4'd0};
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_frame_end = out_frame_end_r;

`ifndef SYNTHESIS
  a_hex_ends_lf: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r && is_last && fmt_r == isfs_pkg::FMT_HEX) |-> byte_nxt == isfs_pkg::ASCII_LF)
    else $error("hex line does not end in LF");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r && fmt_r == isfs_pkg::FMT_BIN) |-> cnt_r <= isfs_pkg::BIN_POS_LAST)
    else $error("binary frame counter overran");
  a_end_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_frame_end_r |-> out_valid_r) else $error("frame end without a beat");
`endif

endmodule

// ===== hdl/imu_sample_frame_serializer.sv =====
// IMU sample frame serializer top level: front end, frame queue and serializer.
// Path of a sample set: capture register, frame queue, serializer, output byte register.
// Throughput: one byte per cycle while a frame is active; a binary frame is 28 bytes, a hex line 58,
//   from the single byte-wide serializer; frames from the queue follow with no gap.
// The output receiver cannot stall; busy rises only while the queue and capture stage are full.
// Synchronous active-low reset clears the format register (binary), queue and serializer.
module imu_sample_frame_serializer #(
  parameter int unsigned FifoDepth = isfs_pkg::FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_gyro_x,
  input  logic [31:0] in_gyro_y,
  input  logic [31:0] in_gyro_z,
  input  logic [31:0] in_accel_x,
  input  logic [31:0] in_accel_y,
  input  logic [31:0] in_accel_z,
  output logic        out_valid,
  output logic [7:0]  out_byte,
  output logic        out_frame_end
);

  isfs_pkg::isfs_fifo_ctl_t fifo_ctl;
  isfs_pkg::isfs_fifo_sts_t fifo_sts;
  isfs_pkg::isfs_frame_t    fe_frame;
  isfs_pkg::isfs_frame_t    q_frame;
  logic                     push;
  logic                     pop;

  assign fifo_ctl.push = push;
  assign fifo_ctl.pop  = pop;

  isfs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .start     (start),
    .busy      (busy),
    .in_words  ({in_gyro_x, in_gyro_y, in_gyro_z, in_accel_x, in_accel_y, in_accel_z}),
    .fifo_sts  (fifo_sts),
    .push      (push),
    .frame     (fe_frame)
  );

  isfs_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (fifo_ctl),
    .sts     (fifo_sts),
    .wr_data (fe_frame),
    .rd_data (q_frame)
  );

  isfs_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .fifo_sts      (fifo_sts),
    .frame         (q_frame),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_byte      (out_byte),
    .out_frame_end (out_frame_end)
  );

endmodule

// ===== tb/sv/imu_sample_frame_serializer_tb.sv =====
// Testbench for the IMU sample frame serializer: byte-stream scoreboard and stimulus.
`timescale 1ns / 1ps

module imu_sample_frame_serializer_tb;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned SETTLE_CYCLE = 12;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  class frame_scoreboard;
    frame_byte_t pending_bytes[$];
    logic        fmt;
    int          errors;

    function new();
      fmt = isfs_pkg::FMT_BIN;
      errors = 0;
    endfunction

    task report(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function void select_format(input logic f);
      fmt = f;
    endfunction

    function int unsigned outstanding();
      return pending_bytes.size();
    endfunction

    function logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] c;
      if (nib < 4'd10) begin
        c = 8'h30 + {4'd0, nib};
      end else begin
        c = 8'h41 + {4'd0, nib} - 8'd10;
      end
      return c;
    endfunction

    function void push_byte(input logic [7:0] b);
      frame_byte_t fb;
      fb.data = b;
      fb.last = 1'b0;
      pending_bytes.push_back(fb);
    endfunction

    // Expand one accepted sample set into its frame bytes.
    function void note_sample(input logic [isfs_pkg::DATA_W-1:0] words);
      logic [isfs_pkg::WORD_W-1:0] w;
      logic [7:0]                  sum;
      frame_byte_t                 tail;
      sum = 8'd0;
      if (fmt == isfs_pkg::FMT_BIN) begin
        push_byte(isfs_pkg::BIN_SYNC0);
        push_byte(isfs_pkg::BIN_SYNC1);
        push_byte(isfs_pkg::BIN_LEN);
        for (int i = 0; i < isfs_pkg::WORD_COUNT; i++) begin
          w = words[isfs_pkg::DATA_W-1-i*isfs_pkg::WORD_W -: isfs_pkg::WORD_W];
          for (int k = 3; k >= 0; k--) begin
            push_byte(w[k*8 +: 8]);
            sum = sum + w[k*8 +: 8];
          end
        end
        push_byte(sum + isfs_pkg::BIN_LEN);
      end else begin
        for (int i = 0; i < isfs_pkg::WORD_COUNT; i++) begin
          w = words[isfs_pkg::DATA_W-1-i*isfs_pkg::WORD_W -: isfs_pkg::WORD_W];
          for (int k = 7; k >= 0; k--) push_byte(hex_char(w[k*4 +: 4]));
          push_byte(isfs_pkg::ASCII_COMMA);
          for (int k = 0; k < 4; k++) sum = sum + w[k*8 +: 8];
        end
        push_byte(hex_char(sum[7:4]));
        push_byte(hex_char(sum[3:0]));
        push_byte(isfs_pkg::ASCII_CR);
        push_byte(isfs_pkg::ASCII_LF);
      end
      tail = pending_bytes.pop_back();
      tail.last = 1'b1;
      pending_bytes.push_back(tail);
    endfunction

    task check_byte(input logic [7:0] b, input logic fe);
      frame_byte_t exp_b;
      if (pending_bytes.size() == 0) begin
        report($sformatf("unexpected byte beat 0x%02h end=%0b", b, fe));
      end else begin
        exp_b = pending_bytes.pop_front();
        if (b !== exp_b.data)
          report($sformatf("out_byte 0x%02h, expected 0x%02h", b, exp_b.data));
        if (fe !== exp_b.last)
          report($sformatf("out_frame_end %0b, expected %0b", fe, exp_b.last));
      end
    endtask
  endclass

  logic                        clk;
  logic                        rst_n = 1'b0;
  logic                        cfg_we = 1'b0;
  logic                        cfg_wdata = 1'b0;
  logic                        start = 1'b0;
  logic                        busy;
  logic [isfs_pkg::DATA_W-1:0] sample_words = '0;
  logic                        out_valid;
  logic [7:0]                  out_byte;
  logic                        out_frame_end;

  frame_scoreboard sb;
  int unsigned     idle_pct;
  int unsigned     cycles = 0;

  imu_sample_frame_serializer dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .start        (start),
    .busy         (busy),
    .in_gyro_x    (sample_words[191:160]),
    .in_gyro_y    (sample_words[159:128]),
    .in_gyro_z    (sample_words[127:96]),
    .in_accel_x   (sample_words[95:64]),
    .in_accel_y   (sample_words[63:32]),
    .in_accel_z   (sample_words[31:0]),
    .out_valid    (out_valid),
    .out_byte     (out_byte),
    .out_frame_end(out_frame_end)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_byte(out_byte, out_frame_end);
  end

  function automatic logic [isfs_pkg::WORD_W-1:0] pick_word();
    logic [isfs_pkg::WORD_W-1:0] w;
    case ($urandom_range(7))
      0:       w = '0;
      1:       w = '1;
      2:       w = $urandom_range(255);
      default: w = $urandom;
    endcase
    return w;
  endfunction

  // start stays high across back-to-back beats; it drops only when idling.
  task send_sample(input logic [isfs_pkg::DATA_W-1:0] words);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    sample_words <= words;
    do @(posedge clk); while (busy);
    sb.note_sample(words);
  endtask

  task send_random(input int unsigned n);
    logic [isfs_pkg::DATA_W-1:0] words;
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < isfs_pkg::WORD_COUNT; k++) begin
        words[k*isfs_pkg::WORD_W +: isfs_pkg::WORD_W] = pick_word();
      end
      send_sample(words);
    end
  endtask

  task drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLE) @(posedge clk);
  endtask

  task write_format(input logic f);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= f;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.select_format(f);
  endtask

  task send_directed();
    send_sample('0);
    send_sample('1);
    send_sample({32'h01234567, 32'h89ABCDEF, 32'hFEDCBA98,
                 32'h76543210, 32'h80000001, 32'h7FFFFFFE});
    send_sample({6{32'hA5A5A5A5}});
    send_sample({32'hDEADBEEF, 32'h0F0F0F0F, 32'hF0F0F0F0,
                 32'h13579BDF, 32'h2468ACE0, 32'h00000001});
  endtask

  initial begin
    sb = new();
    idle_pct = 35;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // binary format straight out of reset
    send_directed();
    write_format(isfs_pkg::FMT_HEX);
    send_directed();

    write_format(isfs_pkg::FMT_BIN);
    send_random(35);

    write_format(isfs_pkg::FMT_HEX);
    send_random(17);
    drain();
    send_random(18);

    // no-idle stretch: frames queue back to back and busy pushes back
    write_format(isfs_pkg::FMT_BIN);
    idle_pct = 0;
    send_random(15);
    idle_pct = 35;
    send_random(15);

    drain();
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/isfs_pkg.sv
hdl/isfs_front.sv
hdl/isfs_fifo.sv
hdl/isfs_back.sv
hdl/imu_sample_frame_serializer.sv
tb/sv/imu_sample_frame_serializer_tb.sv
